/* design/qtp_pkg.sv */
// shared types and constants for the quadtree path bitmap painter
`default_nettype none
package qtp_pkg;

  localparam int unsigned MAX_SIDE  = 64;
  localparam int unsigned MAX_DEPTH = 6;
  localparam int unsigned ROW_W     = $clog2(MAX_SIDE);
  localparam int unsigned SIDE_W    = 7;
  localparam int unsigned CODE_W    = 14;
  localparam int unsigned PIX_W     = 64;
  localparam int unsigned BND_W     = 7;

  // x / 5 as (x * DIV5_MUL) >> DIV5_SHIFT, exact for x below 2**16
  localparam logic [16:0] DIV5_MUL   = 17'd52429;
  localparam int unsigned DIV5_SHIFT = 18;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PAINT = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DECODE = 2'd1,
    ST_PAINT  = 2'd2,
    ST_READ   = 2'd3
  } state_e;

  typedef enum logic [2:0] {
    DIG_NONE = 3'd0,
    DIG_TL   = 3'd1,
    DIG_TR   = 3'd2,
    DIG_BL   = 3'd3,
    DIG_BR   = 3'd4
  } digit_e;

  // one-based inclusive bounds of a rectangle
  typedef struct packed {
    logic [BND_W-1:0] lo_c;
    logic [BND_W-1:0] hi_c;
    logic [BND_W-1:0] lo_r;
    logic [BND_W-1:0] hi_r;
  } rect_t;

  typedef struct packed {
    logic  done;
    logic  empty;
    rect_t rect;
  } dec_out_t;

endpackage
`default_nettype wire

/* design/qtp_path_decode.sv */
// iterative base-5 path code decoder, one digit per cycle
`default_nettype none
module qtp_path_decode (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [qtp_pkg::CODE_W-1:0] code_i,
  input  wire logic [qtp_pkg::BND_W-1:0]  side_i,
  output qtp_pkg::dec_out_t           dec_o
);
  import qtp_pkg::*;

  logic              run_q, run_d;
  logic [CODE_W-1:0] t_q, t_d;
  rect_t             r_q, r_d;

  logic [31:0]       prod;
  logic [CODE_W-1:0] quot;
  logic [CODE_W-1:0] quot5;
  logic [2:0]        digit;
  logic [BND_W:0]    sum_c, sum_r;
  logic [BND_W-1:0]  mc, mr;

  assign prod  = 32'(t_q) * 32'(DIV5_MUL);
  assign quot  = CODE_W'(prod >> DIV5_SHIFT);
  assign quot5 = (quot << 2) + quot;
  assign digit = 3'(t_q - quot5);

  // split point (hi + lo - 1) / 2, lo is never zero
  assign sum_c = {1'b0, r_q.hi_c} + {1'b0, r_q.lo_c} - (BND_W+1)'(1);
  assign sum_r = {1'b0, r_q.hi_r} + {1'b0, r_q.lo_r} - (BND_W+1)'(1);
  assign mc    = sum_c[BND_W:1];
  assign mr    = sum_r[BND_W:1];

  always_comb begin
    run_d = run_q;
    t_d   = t_q;
    r_d   = r_q;
    if (start_i) begin
      run_d  = 1'b1;
      t_d    = code_i;
      r_d.lo_c = BND_W'(1);
      r_d.lo_r = BND_W'(1);
      r_d.hi_c = side_i;
      r_d.hi_r = side_i;
    end else if (run_q) begin
      if (t_q == '0) begin
        run_d = 1'b0;
      end else begin
        t_d = quot;
        case (digit_e'(digit))
          DIG_TL: begin
            r_d.hi_c = mc;
            r_d.hi_r = mr;
          end
          DIG_TR: begin
            r_d.lo_c = mc + BND_W'(1);
            r_d.hi_r = mr;
          end
          DIG_BL: begin
            r_d.hi_c = mc;
            r_d.lo_r = mr + BND_W'(1);
          end
          DIG_BR: begin
            r_d.lo_c = mc + BND_W'(1);
            r_d.lo_r = mr + BND_W'(1);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    r_q <= r_d;
  end

  assign dec_o.done  = run_q && (t_q == '0);
  assign dec_o.empty = (r_q.hi_c < r_q.lo_c) || (r_q.hi_r < r_q.lo_r);
  assign dec_o.rect  = r_q;

endmodule
`default_nettype wire

/* design/quadtree_path_bitmap_painter.sv */
// top level: bitmap store, paint and readout sequencer
//
// Command-driven painter for a square bitmap of up to 64 x 64 pixels held in
// a 64-word by 64-bit synchronous memory (one read and one write per cycle,
// registered read data). A word is taken when start_i is high and busy_o is
// low. Clear drops a per-row valid flag, and an invalid row reads as all
// zero, so no sweep of the memory is needed, also not after reset. Paint
// first decodes the path code one base-5 digit per cycle, then does a
// read-modify-write over the rows of the rectangle, one row per cycle through
// the memory port; busy_o stays high until the last write is done (code 0
// fills every row of the side). Readout reads one row per cycle and shows it
// on the result ports in the cycle after its read. The receiver cannot
// stall: every row is on row_index_o / row_bits_o / last_row_o for exactly
// the one cycle in which row_valid_o is high, and last_row_o marks the final
// row. A side_length above 64 acts as 64; a side of zero paints nothing and a
// readout then gives no rows. The user must write side_length through
// side_length_we_i only while the block is idle; the block does not
// enforce this.
`default_nettype none
module quadtree_path_bitmap_painter (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output      logic                        busy_o,
  input  wire logic [1:0]                  command_i,
  input  wire logic [qtp_pkg::CODE_W-1:0]  path_code_i,
  input  wire logic                        side_length_we_i,
  input  wire logic [qtp_pkg::SIDE_W-1:0]  side_length_i,
  output      logic                        row_valid_o,
  output      logic [qtp_pkg::ROW_W-1:0]   row_index_o,
  output      logic [qtp_pkg::PIX_W-1:0]   row_bits_o,
  output      logic                        last_row_o
);
  import qtp_pkg::*;

  // configuration
  logic [SIDE_W-1:0] side_q;
  logic [BND_W-1:0]  side_eff;

  // sequencer
  state_e            state_q, state_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ROW_W-1:0]  row_end_q, row_end_d;
  logic [PIX_W-1:0]  mask_q, mask_d;

  // bitmap store
  logic [PIX_W-1:0]  mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] row_vld_q;
  logic [PIX_W-1:0]  rdata_q;
  logic [PIX_W-1:0]  rdata_eff;

  // read stage: what to do with the word coming out of the memory
  logic              st_paint_q, st_emit_q;
  logic [ROW_W-1:0]  st_row_q;
  logic              st_last_q;

  // sequencer outputs
  logic              accept;
  logic              rd_en;
  logic              rd_paint;
  logic              rd_emit;
  logic              rd_last;
  logic              clear_all;
  logic              dec_start;

  dec_out_t          dec;

  logic [ROW_W-1:0]  lo_sh;
  logic [ROW_W-1:0]  hi_sh;

  assign side_eff = (side_q > SIDE_W'(MAX_SIDE)) ? BND_W'(MAX_SIDE) : BND_W'(side_q);
  assign busy_o   = (state_q != ST_IDLE) || st_paint_q || st_emit_q;
  assign accept   = start_i && !busy_o;

  qtp_path_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dec_start),
    .code_i (path_code_i),
    .side_i (side_eff),
    .dec_o  (dec)
  );

  // column mask lo..hi, both one-based, hi >= lo >= 1 when painting
  assign lo_sh = ROW_W'(dec.rect.lo_c - BND_W'(1));
  assign hi_sh = ROW_W'(BND_W'(MAX_SIDE) - dec.rect.hi_c);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_PAINT: state_d = ST_DECODE;
            CMD_READ: begin
              if (side_eff != '0) begin
                state_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DECODE: begin
        if (dec.done) begin
          state_d = dec.empty ? ST_IDLE : ST_PAINT;
        end
      end
      ST_PAINT, ST_READ: begin
        if (row_q == row_end_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs and row counter
  always_comb begin
    rd_en     = 1'b0;
    rd_paint  = 1'b0;
    rd_emit   = 1'b0;
    rd_last   = (row_q == row_end_q);
    clear_all = 1'b0;
    dec_start = 1'b0;
    row_d     = row_q;
    row_end_d = row_end_q;
    mask_d    = mask_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_CLEAR: clear_all = 1'b1;
            CMD_PAINT: dec_start = 1'b1;
            CMD_READ: begin
              row_d     = '0;
              row_end_d = ROW_W'(side_eff - BND_W'(1));
            end
            default: ;
          endcase
        end
      end
      ST_DECODE: begin
        row_d     = ROW_W'(dec.rect.lo_r - BND_W'(1));
        row_end_d = ROW_W'(dec.rect.hi_r - BND_W'(1));
        mask_d    = ({PIX_W{1'b1}} << lo_sh) & ({PIX_W{1'b1}} >> hi_sh);
      end
      ST_PAINT: begin
        rd_en    = 1'b1;
        rd_paint = 1'b1;
        row_d    = row_q + ROW_W'(1);
      end
      ST_READ: begin
        rd_en   = 1'b1;
        rd_emit = 1'b1;
        row_d   = row_q + ROW_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      side_q     <= SIDE_W'(MAX_SIDE);
      st_paint_q <= 1'b0;
      st_emit_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      st_paint_q <= rd_paint;
      st_emit_q  <= rd_emit;
      if (side_length_we_i) begin
        side_q <= side_length_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q     <= row_d;
    row_end_q <= row_end_d;
    mask_q    <= mask_d;
    st_row_q  <= row_q;
    st_last_q <= rd_last;
  end

  // row valid flags: clear drops all, a paint write sets its row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (clear_all) begin
      row_vld_q <= '0;
    end else if (st_paint_q) begin
      row_vld_q[st_row_q] <= 1'b1;
    end
  end

  // memory read port, registered data
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[row_q];
    end
  end

  // an invalid row reads as zero; rows of one paint are distinct, so the
  // read of the next row never collides with the write-back of this one
  assign rdata_eff = row_vld_q[st_row_q] ? rdata_q : '0;

  // memory write port, or the mask into the row
  always_ff @(posedge clk_i) begin
    if (st_paint_q) begin
      mem[st_row_q] <= rdata_eff | mask_q;
    end
  end

  // readout word, shown for one cycle
  assign row_valid_o = st_emit_q;
  assign row_index_o = st_row_q;
  assign row_bits_o  = rdata_eff;
  assign last_row_o  = st_last_q;

endmodule
`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the quadtree path bitmap painter
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import qtp_pkg::*;

  // command code with no operation behind it
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RADIX      = 5;
  // quiet cycles before a side write, covers the longest paint
  localparam int SETTLE     = 90;
  // cycles watched for stray rows after the last expected one
  localparam int TAIL       = 120;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 9;
  localparam int DIR_N      = 25;

  typedef enum logic {OP_CMD, OP_CFG} stim_op_e;

  // one row of the directed table; fixed_rows holds a row value typed in by hand for every readout row
  typedef struct {
    stim_op_e         op;
    logic [1:0]       cmd;
    logic [CODE_W-1:0] code;
    logic [SIDE_W-1:0] side;
    logic             fixed;
    logic [PIX_W-1:0] fixed_rows;
  } stim_t;

  typedef struct packed {
    logic [ROW_W-1:0] idx;
    logic [PIX_W-1:0] bits;
    logic             last;
  } row_word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [1:0]          command_i;
  logic [CODE_W-1:0]   path_code_i;
  logic                side_length_we_i;
  logic [SIDE_W-1:0]   side_length_i;
  logic                row_valid_o;
  logic [ROW_W-1:0]    row_index_o;
  logic [PIX_W-1:0]    row_bits_o;
  logic                last_row_o;

  // predicted image and side register
  logic [PIX_W-1:0]    image_rows [MAX_SIDE];
  logic [SIDE_W-1:0]   side_reg;
  // rows still owed by the block, oldest first
  row_word_t           expected_rows [$];

  int  errors;
  int  words_sent;
  int  rows_checked;
  int  side_writes;
  bit  burst;

  stim_t dir_tbl [DIR_N];

  quadtree_path_bitmap_painter DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .command_i        (command_i),
    .path_code_i      (path_code_i),
    .side_length_we_i (side_length_we_i),
    .side_length_i    (side_length_i),
    .row_valid_o      (row_valid_o),
    .row_index_o      (row_index_o),
    .row_bits_o       (row_bits_o),
    .last_row_o       (last_row_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // hard stop well past the slowest correct run
  initial begin
    #5_000_000;
    $display("FAIL quadtree_path_bitmap_painter");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    errors++;
  endtask

  // a side above the store acts as the full store
  function automatic int eff_side();
    if (side_reg > SIDE_W'(MAX_SIDE)) return MAX_SIDE;
    return int'(side_reg);
  endfunction

  // walk the base-5 digits and set the rectangle they lead to
  function automatic void predict_paint(input logic [CODE_W-1:0] code);
    int unsigned t;
    int n, lo_c, hi_c, lo_r, hi_r, mc, mr, dgt, w, i;
    logic [PIX_W-1:0] m;
    n = eff_side();
    lo_c = 1;
    hi_c = n;
    lo_r = 1;
    hi_r = n;
    t = code;
    while (t != 0) begin
      dgt = t % RADIX;
      mc = (hi_c + lo_c - 1) / 2;
      mr = (hi_r + lo_r - 1) / 2;
      t = t / RADIX;
      if (dgt == DIG_TL) begin
        hi_c = mc;
        hi_r = mr;
      end else if (dgt == DIG_TR) begin
        lo_c = mc + 1;
        hi_r = mr;
      end else if (dgt == DIG_BL) begin
        hi_c = mc;
        lo_r = mr + 1;
      end else if (dgt == DIG_BR) begin
        lo_c = mc + 1;
        lo_r = mr + 1;
      end
    end
    // halving a one-pixel span can leave nothing
    if (hi_c < lo_c || hi_r < lo_r) return;
    w = hi_c - lo_c + 1;
    if (w >= PIX_W) m = '1;
    else m = ((64'd1 << w) - 64'd1) << (lo_c - 1);
    for (i = lo_r; i <= hi_r; i++) image_rows[i-1] |= m;
  endfunction

  // add one row at the tail of the owed list
  function automatic void owe_row(input row_word_t r);
    expected_rows.insert(expected_rows.size(), r);
  endfunction

  // rows a readout owes; a typed-in row value replaces the prediction
  function automatic void queue_readout(input logic fixed, input logic [PIX_W-1:0] fixed_rows);
    int n, i;
    row_word_t r;
    n = eff_side();
    for (i = 0; i < n; i++) begin
      r.idx  = ROW_W'(i);
      r.bits = fixed ? fixed_rows : image_rows[i];
      r.last = (i == n - 1);
      owe_row(r);
    end
  endfunction

  function automatic void predict_word(input logic [1:0] cmd, input logic [CODE_W-1:0] code,
                                       input logic fixed, input logic [PIX_W-1:0] fixed_rows);
    int i;
    case (cmd)
      CMD_CLEAR: begin
        for (i = 0; i < MAX_SIDE; i++) image_rows[i] = '0;
      end
      CMD_PAINT: predict_paint(code);
      CMD_READ:  queue_readout(fixed, fixed_rows);
      default: ;
    endcase
  endfunction

  // one word through the start/busy handshake, after a random gap outside bursts
  task automatic send_word(input logic [1:0] cmd, input logic [CODE_W-1:0] code,
                           input logic fixed, input logic [PIX_W-1:0] fixed_rows);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 13);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command_i   = cmd;
    path_code_i = code;
    start_i     = 1'b1;
    do @(posedge clk_i); while (busy_o);
    predict_word(cmd, code, fixed, fixed_rows);
    words_sent++;
  endtask

  // stop sending until every owed row is out and the block has gone quiet
  task automatic drain_block();
    @(negedge clk_i);
    start_i = 1'b0;
    while (expected_rows.size() != 0) @(negedge clk_i);
    // paints leave no row behind, so give them time to finish
    repeat (SETTLE) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
  endtask

  task automatic write_side(input logic [SIDE_W-1:0] v);
    drain_block();
    side_length_i    = v;
    side_length_we_i = 1'b1;
    @(negedge clk_i);
    side_length_we_i = 1'b0;
    side_reg = v;
    side_writes++;
  endtask

  // random leaf code of the given depth, digits mostly nonzero
  function automatic logic [CODE_W-1:0] leaf_code(input int depth);
    int unsigned code, mult, d;
    int i;
    code = 0;
    mult = 1;
    for (i = 0; i < depth; i++) begin
      d = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      code += d * mult;
      mult *= RADIX;
    end
    // a seventh digit may not fit in the field
    if (code > 16383) code = code % 15625;
    return CODE_W'(code);
  endfunction

  // result checker: every strobed row against the oldest expectation
  always @(posedge clk_i) begin
    row_word_t e;
    if (rst_ni && row_valid_o) begin
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("row %0d came with nothing expected", row_index_o));
      end else begin
        e = expected_rows.pop_front();
        rows_checked++;
        if (row_index_o !== e.idx)
          report_mismatch($sformatf("row_index %0d, expected %0d", row_index_o, e.idx));
        if (row_bits_o !== e.bits)
          report_mismatch($sformatf("row %0d bits %h, expected %h", e.idx, row_bits_o, e.bits));
        if (last_row_o !== e.last)
          report_mismatch($sformatf("row %0d last_row %b, expected %b", e.idx, last_row_o,
                                    e.last));
      end
    end
  end

  initial begin
    int p, k, r, i;
    logic [SIDE_W-1:0] phase_side;
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    command_i        = CMD_CLEAR;
    path_code_i      = '0;
    side_length_we_i = 1'b0;
    side_length_i    = SIDE_W'(MAX_SIDE);
    errors       = 0;
    words_sent   = 0;
    rows_checked = 0;
    side_writes  = 0;
    burst        = 1'b0;
    side_reg     = SIDE_W'(MAX_SIDE);
    for (i = 0; i < MAX_SIDE; i++) image_rows[i] = '0;

    // directed table: reset state, fills, side extremes, deep codes, stale pixels
    dir_tbl = '{
      '{OP_CMD, CMD_READ,   14'd0,     7'd0,   1'b1, 64'd0},           // image after reset
      '{OP_CMD, CMD_PAINT,  14'd0,     7'd0,   1'b0, 64'd0},           // code 0 fills all
      '{OP_CMD, CMD_READ,   14'd0,     7'd0,   1'b1, {64{1'b1}}},
      '{OP_CMD, CMD_CLEAR,  14'd0,     7'd0,   1'b0, 64'd0},
      '{OP_CMD, CMD_READ,   14'd0,     7'd0,   1'b1, 64'd0},
      '{OP_CFG, CMD_CLEAR,  14'd0,     7'd1,   1'b0, 64'd0},           // smallest side
      '{OP_CMD, CMD_PAINT,  14'd0,     7'd0,   1'b0, 64'd0},
      '{OP_CMD, CMD_READ,   14'd0,     7'd0,   1'b1, 64'd1},
      '{OP_CFG, CMD_CLEAR,  14'd0,     7'd0,   1'b0, 64'd0},           // side zero
      '{OP_CMD, CMD_PAINT,  14'd0,     7'd0,   1'b0, 64'd0},
      '{OP_CMD, CMD_READ,   14'd0,     7'd0,   1'b0, 64'd0},           // no rows at all
      '{OP_CMD, CMD_UNUSED, 14'd16383, 7'd0,   1'b0, 64'd0},
      '{OP_CFG, CMD_CLEAR,  14'd0,     7'd127, 1'b0, 64'd0},           // side above store
      '{OP_CMD, CMD_READ,   14'd0,     7'd0,   1'b0, 64'd0},
      '{OP_CMD, CMD_PAINT,  14'd4,     7'd0,   1'b0, 64'd0},           // bottom-right quadrant
      '{OP_CMD, CMD_PAINT,  14'd16383, 7'd0,   1'b0, 64'd0},           // all code bits set
      '{OP_CMD, CMD_PAINT,  14'd15624, 7'd0,   1'b0, 64'd0},           // six bottom-right digits
      '{OP_CFG, CMD_CLEAR,  14'd0,     7'd5,   1'b0, 64'd0},           // odd side, no clear
      '{OP_CMD, CMD_PAINT,  14'd2,     7'd0,   1'b0, 64'd0},
      '{OP_CMD, CMD_PAINT,  14'd31,    7'd0,   1'b0, 64'd0},           // halves down to empty
      '{OP_CMD, CMD_PAINT,  14'd3,     7'd0,   1'b0, 64'd0},
      '{OP_CMD, CMD_READ,   14'd0,     7'd0,   1'b0, 64'd0},
      '{OP_CFG, CMD_CLEAR,  14'd0,     7'd64,  1'b0, 64'd0},
      '{OP_CMD, CMD_READ,   14'd0,     7'd0,   1'b0, 64'd0},           // stale pixels show
      '{OP_CMD, CMD_UNUSED, 14'd0,     7'd0,   1'b0, 64'd0}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (k = 0; k < DIR_N; k++) begin
      if (dir_tbl[k].op == OP_CFG) write_side(dir_tbl[k].side);
      else send_word(dir_tbl[k].cmd, dir_tbl[k].code, dir_tbl[k].fixed,
                     dir_tbl[k].fixed_rows);
    end

    // random phases, each at its own side, extremes included
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_side = 7'd64;
        1: phase_side = 7'd1;
        2: phase_side = 7'd0;
        3: phase_side = 7'd127;
        default: phase_side = SIDE_W'($urandom_range(2, 64));
      endcase
      write_side(phase_side);
      burst = ($urandom_range(0, 2) == 0);
      for (k = 0; k < PHASE_LEN; k++) begin
        // now and then hold off until the block has emptied
        if ($urandom_range(0, 11) == 0) drain_block();
        r = $urandom_range(0, 99);
        if (r < 8)       send_word(CMD_CLEAR, CODE_W'($urandom_range(0, 16383)), 1'b0, '0);
        else if (r < 12) send_word(CMD_UNUSED, CODE_W'($urandom_range(0, 16383)), 1'b0, '0);
        else if (r < 22) send_word(CMD_PAINT, CODE_W'($urandom_range(0, 16383)), 1'b0, '0);
        else if (r < 82) send_word(CMD_PAINT, leaf_code($urandom_range(0, 7)), 1'b0, '0);
        else             send_word(CMD_READ, CODE_W'($urandom_range(0, 16383)), 1'b0, '0);
      end
      send_word(CMD_READ, '0, 1'b0, '0);
    end
    burst = 1'b0;

    @(negedge clk_i);
    start_i = 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    $display("covered %0d command words and %0d readout rows over %0d side settings",
             words_sent, rows_checked, side_writes);
    $display("sides included zero, one, 64 and above the store; %0d mismatches", errors);
    if (errors == 0) begin
      $display("PASS quadtree_path_bitmap_painter");
    end else begin
      $display("FAIL quadtree_path_bitmap_painter");
    end
    $finish;
  end

endmodule
`default_nettype wire
